/* hdl/qbpm_pkg.sv */
// Shared types, constants and a helper function for the quad bilinear point map.
package qbpm_pkg;

  localparam int COORD_BITS      = 16;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS   = 8;

  localparam int SHEET_W  = 16;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 3;
  localparam int OUT_W    = 24;
  localparam int STATUS_W = 2;

  localparam int CW       = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int UW       = RATIO_FRAC_BITS + 1;
  localparam int EDGE_W   = CW + RATIO_FRAC_BITS;
  localparam int Q_W      = CW + RATIO_FRAC_BITS + 1;

  localparam logic [UW-1:0] RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

  localparam int DIV_STEPS           = RATIO_FRAC_BITS + 1;
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          = (DIV_STEPS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
  localparam int MIX_STAGES          = 4;
  localparam int PIPE_STAGES         = DIV_STAGES + MIX_STAGES + 1;

  localparam int RND_SH = RATIO_FRAC_BITS - OUT_FRAC_BITS;
  localparam int SH_R   = (RND_SH > 0) ? RND_SH : 1;
  localparam int SH_L   = (RND_SH < 0) ? -RND_SH : 0;
  localparam int RND_W  = Q_W + 1 + SH_L;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_TOP_LEFT     = 3'd0;
  localparam logic [IDX_W-1:0] REG_TOP_RIGHT    = 3'd1;
  localparam logic [IDX_W-1:0] REG_BOTTOM_LEFT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_BOTTOM_RIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_WIDTH        = 3'd4;
  localparam logic [IDX_W-1:0] REG_HEIGHT       = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CLAMP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;

  typedef struct packed {
    logic [SHEET_W-1:0] sheet_x;
    logic [SHEET_W-1:0] sheet_y;
  } point_in_t;

  typedef struct packed {
    logic [OUT_W-1:0]    mapped_x;
    logic [OUT_W-1:0]    mapped_y;
    logic [STATUS_W-1:0] map_status;
  } point_out_t;

  typedef struct packed {
    logic zero;
    logic cx;
    logic cy;
  } meta_t;

  // Round half up to the output fraction width, then saturate.
  function automatic logic [OUT_W-1:0] to_out(input logic [Q_W-1:0] q);
    logic [RND_W-1:0] r;
    if (RND_SH > 0) begin
      r = (RND_W'(q) + (RND_W'(1) << (SH_R - 1))) >> SH_R;
    end else begin
      r = RND_W'(q) << SH_L;
    end
    if (r > RND_W'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return r[OUT_W-1:0];
  endfunction

endpackage

/* hdl/qbpm_ratio_div.sv */
// Pipelined restoring divider forming a ratio num * 2^R / den, two bits per stage, one in the last.
module qbpm_ratio_div (
  input  logic                                 clk,
  input  logic [qbpm_pkg::DIV_STAGES-1:0]      en,
  input  logic [qbpm_pkg::SHEET_W-1:0]         num,
  input  logic [qbpm_pkg::SHEET_W-1:0]         den,
  output logic [qbpm_pkg::UW-1:0]              quo
);

  localparam int RW = qbpm_pkg::SHEET_W + 1;

  logic [RW-1:0]           rem_q [qbpm_pkg::DIV_STAGES];
  logic [qbpm_pkg::UW-1:0] quo_q [qbpm_pkg::DIV_STAGES];

  for (genvar s = 0; s < qbpm_pkg::DIV_STAGES; s++) begin : g_stage
    logic [RW-1:0]           rem_in;
    logic [qbpm_pkg::UW-1:0] quo_in;
    logic [RW-1:0]           rem_out;
    logic [qbpm_pkg::UW-1:0] quo_out;

    if (s == 0) begin : g_first
      assign rem_in = {1'b0, num};
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      logic          ge;
      logic [RW-1:0] diff;
      ge      = 1'b0;
      diff    = '0;
      rem_out = rem_in;
      quo_out = quo_in;
      for (int t = 0; t < qbpm_pkg::DIV_STEPS_PER_STAGE; t++) begin
        if (s * qbpm_pkg::DIV_STEPS_PER_STAGE + t < qbpm_pkg::DIV_STEPS) begin
          ge      = rem_out >= {1'b0, den};
          diff    = ge ? (rem_out - {1'b0, den}) : rem_out;
          quo_out = {quo_out[qbpm_pkg::UW-2:0], ge};
          rem_out = {diff[RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_q[s] <= rem_out;
        quo_q[s] <= quo_out;
      end
    end
  end

  assign quo = quo_q[qbpm_pkg::DIV_STAGES-1];

endmodule

/* hdl/qbpm_axis_mix.sv */
// Four-stage bilinear mix of one coordinate axis: edge products, edge sums, blend products, sum.
module qbpm_axis_mix (
  input  logic                              clk,
  input  logic [qbpm_pkg::MIX_STAGES-1:0]   en,
  input  logic [qbpm_pkg::CW-1:0]           c_tl,
  input  logic [qbpm_pkg::CW-1:0]           c_tr,
  input  logic [qbpm_pkg::CW-1:0]           c_bl,
  input  logic [qbpm_pkg::CW-1:0]           c_br,
  input  logic [qbpm_pkg::UW-1:0]           u,
  input  logic [qbpm_pkg::UW-1:0]           v,
  output logic [qbpm_pkg::Q_W-1:0]          q
);

  localparam int R  = qbpm_pkg::RATIO_FRAC_BITS;
  localparam int PW = qbpm_pkg::CW + qbpm_pkg::UW;
  localparam int LW = R + qbpm_pkg::UW;

  logic [PW-1:0]               p_tl, p_tr, p_bl, p_br;
  logic [qbpm_pkg::UW-1:0]     v0, v1;
  logic [qbpm_pkg::EDGE_W-1:0] top_e, bot_e;
  logic [PW-1:0]               m_th, m_bh;
  logic [LW-1:0]               m_tl, m_bl;

  logic [qbpm_pkg::UW-1:0]     u_inv;
  logic [PW:0]                 top_sum, bot_sum, hi_sum;
  logic [LW:0]                 lo_sum;

  assign u_inv   = qbpm_pkg::RATIO_ONE - u;
  assign top_sum = (PW+1)'(p_tl) + (PW+1)'(p_tr);
  assign bot_sum = (PW+1)'(p_bl) + (PW+1)'(p_br);
  assign hi_sum  = (PW+1)'(m_th) + (PW+1)'(m_bh);
  assign lo_sum  = (LW+1)'(m_tl) + (LW+1)'(m_bl);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_tl <= PW'(c_tl) * PW'(u_inv);
      p_tr <= PW'(c_tr) * PW'(u);
      p_bl <= PW'(c_bl) * PW'(u_inv);
      p_br <= PW'(c_br) * PW'(u);
      v0   <= v;
    end
    if (en[1]) begin
      top_e <= top_sum[qbpm_pkg::EDGE_W-1:0];
      bot_e <= bot_sum[qbpm_pkg::EDGE_W-1:0];
      v1    <= v0;
    end
    if (en[2]) begin
      m_th <= PW'(top_e[qbpm_pkg::EDGE_W-1:R]) * PW'(qbpm_pkg::RATIO_ONE - v1);
      m_bh <= PW'(bot_e[qbpm_pkg::EDGE_W-1:R]) * PW'(v1);
      m_tl <= LW'(top_e[R-1:0]) * LW'(qbpm_pkg::RATIO_ONE - v1);
      m_bl <= LW'(bot_e[R-1:0]) * LW'(v1);
    end
    if (en[3]) begin
      q <= hi_sum[qbpm_pkg::Q_W-1:0] + qbpm_pkg::Q_W'(lo_sum[LW:R]);
    end
  end

endmodule

/* hdl/quad_bilinear_point_map.sv */
// Top level of the quad bilinear point map: configuration, stage control and output rounding.
//
//   Channel   Signals                          Direction  Beat contents
//   input     in_valid, in_ready, in_data      in         sheet_x, sheet_y
//   output    out_valid, out_ready, out_data   out        mapped_x, mapped_y, map_status
//   config    cfg_we, cfg_index, cfg_wdata     in         one register write per cycle
//
// One point enters per cycle while in_ready is high; a point passes through 9 divider stages
// (two quotient bits each, one in the last), 4 mix stages (two multiply stages and two add
// stages) and the output register.
// Reset clears the configuration registers and all stage valid bits.
// A stage holds while its successor is full and stalled, so empty stages keep filling
// and no beat is dropped or repeated.
module quad_bilinear_point_map (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  qbpm_pkg::point_in_t            in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output qbpm_pkg::point_out_t           out_data,
  input  logic                           cfg_we,
  input  logic [qbpm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [qbpm_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int NS  = qbpm_pkg::PIPE_STAGES;
  localparam int DS  = qbpm_pkg::DIV_STAGES;
  localparam int MS  = qbpm_pkg::MIX_STAGES;
  localparam int CW  = qbpm_pkg::CW;

  logic [qbpm_pkg::CFG_W-1:0]   corner_tl, corner_tr, corner_bl, corner_br;
  logic [qbpm_pkg::SHEET_W-1:0] sheet_width, sheet_height;

  logic [NS-1:0]           vld;
  logic [NS-1:0]           adv;
  qbpm_pkg::meta_t         meta [NS-1];
  qbpm_pkg::meta_t         meta_in;

  logic [qbpm_pkg::UW-1:0] u_quo, v_quo, u_sel, v_sel;
  logic [qbpm_pkg::Q_W-1:0] q_x, q_y;
  qbpm_pkg::meta_t         meta_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_tl    <= '0;
      corner_tr    <= '0;
      corner_bl    <= '0;
      corner_br    <= '0;
      sheet_width  <= '0;
      sheet_height <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qbpm_pkg::REG_TOP_LEFT:     corner_tl    <= cfg_wdata;
        qbpm_pkg::REG_TOP_RIGHT:    corner_tr    <= cfg_wdata;
        qbpm_pkg::REG_BOTTOM_LEFT:  corner_bl    <= cfg_wdata;
        qbpm_pkg::REG_BOTTOM_RIGHT: corner_br    <= cfg_wdata;
        qbpm_pkg::REG_WIDTH:        sheet_width  <= cfg_wdata[qbpm_pkg::SHEET_W-1:0];
        qbpm_pkg::REG_HEIGHT:       sheet_height <= cfg_wdata[qbpm_pkg::SHEET_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv[NS-1] = !vld[NS-1] || out_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign meta_in.zero = (sheet_width == '0) || (sheet_height == '0);
  assign meta_in.cx   = in_data.sheet_x > sheet_width;
  assign meta_in.cy   = in_data.sheet_y > sheet_height;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      meta[0] <= meta_in;
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (adv[k]) begin
        meta[k] <= meta[k-1];
      end
    end
  end

  qbpm_ratio_div u_div_x (
    .clk (clk),
    .en  (adv[DS-1:0]),
    .num (in_data.sheet_x),
    .den (sheet_width),
    .quo (u_quo)
  );

  qbpm_ratio_div u_div_y (
    .clk (clk),
    .en  (adv[DS-1:0]),
    .num (in_data.sheet_y),
    .den (sheet_height),
    .quo (v_quo)
  );

  assign u_sel = meta[DS-1].cx ? qbpm_pkg::RATIO_ONE : u_quo;
  assign v_sel = meta[DS-1].cy ? qbpm_pkg::RATIO_ONE : v_quo;

  qbpm_axis_mix u_mix_x (
    .clk  (clk),
    .en   (adv[DS+MS-1:DS]),
    .c_tl (corner_tl[CW-1:0]),
    .c_tr (corner_tr[CW-1:0]),
    .c_bl (corner_bl[CW-1:0]),
    .c_br (corner_br[CW-1:0]),
    .u    (u_sel),
    .v    (v_sel),
    .q    (q_x)
  );

  qbpm_axis_mix u_mix_y (
    .clk  (clk),
    .en   (adv[DS+MS-1:DS]),
    .c_tl (corner_tl[16+CW-1:16]),
    .c_tr (corner_tr[16+CW-1:16]),
    .c_bl (corner_bl[16+CW-1:16]),
    .c_br (corner_br[16+CW-1:16]),
    .u    (u_sel),
    .v    (v_sel),
    .q    (q_y)
  );

  assign meta_last = meta[NS-2];

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      if (meta_last.zero) begin
        out_data.mapped_x   <= '0;
        out_data.mapped_y   <= '0;
        out_data.map_status <= qbpm_pkg::ST_ZERO;
      end else begin
        out_data.mapped_x   <= qbpm_pkg::to_out(q_x);
        out_data.mapped_y   <= qbpm_pkg::to_out(q_y);
        out_data.map_status <= (meta_last.cx || meta_last.cy) ? qbpm_pkg::ST_CLAMP
                                                              : qbpm_pkg::ST_OK;
      end
    end
  end

  assign out_valid = vld[NS-1];

  a_zero_gives_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.map_status == qbpm_pkg::ST_ZERO |->
      out_data.mapped_x == '0 && out_data.mapped_y == '0)
    else $error("zero sheet size beat carries a nonzero point");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.map_status == qbpm_pkg::ST_OK ||
                  out_data.map_status == qbpm_pkg::ST_CLAMP ||
                  out_data.map_status == qbpm_pkg::ST_ZERO)
    else $error("output status out of range");

  a_ratio_bound: assert property (@(posedge clk) disable iff (rst)
    vld[DS-1] && !meta[DS-1].zero |-> u_sel <= qbpm_pkg::RATIO_ONE &&
                                      v_sel <= qbpm_pkg::RATIO_ONE)
    else $error("ratio above one after divider");

  a_empty_front_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> in_ready)
    else $error("input stalled while first stage is empty");

  a_drain_moves: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !vld[NS-2] |=> !out_valid)
    else $error("taken beat repeated at output");

endmodule
